### sv/epd_pkg.sv
// Shared constants, types and codes for the escaped packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package epd_pkg;

  localparam int PACKET_BYTES = 16;
  localparam int STORE_DEPTH  = 16;
  localparam int COUNT_W      = $clog2(PACKET_BYTES + 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(PACKET_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(PACKET_BYTES - 1);

  typedef enum logic [2:0] {
    MODE_WAIT    = 3'b001,
    MODE_NORMAL  = 3'b010,
    MODE_ESCAPED = 3'b100
  } mode_t;

  // Control from the framing sequencer to the cell row and output stage.
  typedef struct packed {
    logic       store_en;
    logic [7:0] store_data;
    logic       emit;
  } ctrl_t;

  // Status from the framing sequencer.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               waiting;
  } status_t;

endpackage

`default_nettype wire

### sv/epd_cell.sv
// One byte cell of the packet shift row.
`timescale 1ns / 1ps
`default_nettype none

module epd_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

### sv/epd_ctrl.sv
// Framing sequencer: flag/escape handling, byte count and packet completion.
`timescale 1ns / 1ps
`default_nettype none

module epd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output epd_pkg::ctrl_t   ctrl,
  output epd_pkg::status_t status
);
  import epd_pkg::*;

  mode_t              mode;
  mode_t              mode_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  mode_t              mode_eff;
  logic               is_flag;

  always_comb begin
    is_flag         = (rx_byte == FLAG_BYTE);
    mode_eff        = is_flag ? MODE_WAIT : mode;
    mode_next       = mode;
    count_next      = count;
    ctrl.store_en   = 1'b0;
    ctrl.store_data = rx_byte;
    ctrl.emit       = 1'b0;
    if (accept) begin
      case (mode_eff)
        MODE_NORMAL: begin
          if (rx_byte == ESC_BYTE) begin
            mode_next = MODE_ESCAPED;
          end else begin
            ctrl.store_en = 1'b1;
            count_next    = count + 1'b1;
          end
        end
        MODE_ESCAPED: begin
          ctrl.store_en   = 1'b1;
          ctrl.store_data = rx_byte ^ ESC_XOR;
          count_next      = count + 1'b1;
          mode_next       = MODE_NORMAL;
        end
        default: begin
          count_next = '0;
          mode_next  = is_flag ? MODE_NORMAL : MODE_WAIT;
        end
      endcase
      if (ctrl.store_en && count_next == COUNT_FULL) begin
        ctrl.emit = 1'b1;
        mode_next = MODE_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_WAIT;
      count <= '0;
    end else begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

  assign status.count   = count;
  assign status.waiting = (mode == MODE_WAIT);

endmodule

`default_nettype wire

### sv/escaped_packet_deframer_top.sv
// Top level of the escaped packet deframer: sequencer, byte cell row, output register.
//
//  channel  valid      stall      payload
//  in       in_valid   in_stall   rx_byte
//  out      out_valid  out_stall  packet_low_word, packet_high_word
//
// One byte is taken every cycle unless in_stall holds it; the sequencer registers mode and count as each byte is taken.
// A completed packet is loaded into the output register the cycle after its last byte.
// Input stalls only when the output still holds an untaken packet and the next
// byte could finish another one.
// Reset (rst, synchronous) returns to waiting for a flag with an empty count.
`timescale 1ns / 1ps
`default_nettype none

module escaped_packet_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] packet_low_word,
  output logic [63:0] packet_high_word
);
  import epd_pkg::*;

  ctrl_t      ctrl;
  status_t    status;
  logic       accept;
  logic       load_pending;
  logic [7:0] cell_q [PACKET_BYTES];
  logic [7:0] pkt_byte [STORE_DEPTH];

  assign in_stall = out_valid && out_stall && !status.waiting
                    && (status.count == COUNT_LAST);
  assign accept   = in_valid && !in_stall;

  epd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .ctrl    (ctrl),
    .status  (status)
  );

  // Newest byte enters cell 0; after a full packet, byte 0 sits in the last cell.
  for (genvar k = 0; k < PACKET_BYTES; k++) begin : g_cell
    epd_cell u_cell (
      .clk      (clk),
      .shift_en (ctrl.store_en),
      .d        ((k == 0) ? ctrl.store_data : cell_q[(k == 0) ? 0 : k - 1]),
      .q        (cell_q[k])
    );
  end

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i < PACKET_BYTES) begin
        pkt_byte[i] = cell_q[PACKET_BYTES - 1 - i];
      end else begin
        pkt_byte[i] = 8'h00;
      end
    end
  end

  // No byte is stored in the cycle after a completion, so the row is stable here.
  always_ff @(posedge clk) begin
    if (load_pending) begin
      for (int i = 0; i < 8; i++) begin
        packet_low_word[8*i +: 8]  <= pkt_byte[i];
        packet_high_word[8*i +: 8] <= pkt_byte[i + 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      load_pending <= ctrl.emit;
      if (load_pending) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_pending |-> !out_valid)
    else $error("packet load while output still holds a packet");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_pending |=> out_valid)
    else $error("loaded packet not presented");

  a_wait_after_emit: assert property (@(posedge clk) disable iff (rst)
    load_pending |-> (status.waiting && !ctrl.store_en))
    else $error("byte stored in the cycle after a completed packet");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= COUNT_FULL)
    else $error("byte count past packet length");

endmodule

`default_nettype wire

### dv/escaped_packet_deframer_top_tb.sv
// Self-checking testbench for the escaped packet deframer: byte stream in, packets out.
`timescale 1ns / 1ps

module escaped_packet_deframer_top_tb;
  import epd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1800;
  localparam int HOLD_AT_BYTE  = 700;
  localparam int HOLD_CYCLES   = 300;
  localparam int N_DIRECTED    = 28;

  // Noise before the first flag, flag while normal, flag while escaped, then one
  // full packet with escaped flag, escaped escape and a double escape; the byte
  // after the packet, which must be dropped, is queued separately.
  localparam logic [8*N_DIRECTED-1:0] DIRECTED = {
    8'h00, 8'hFF, ESC_BYTE,
    FLAG_BYTE, 8'h11, FLAG_BYTE, 8'h22, ESC_BYTE, FLAG_BYTE,
    8'hFF, 8'h00, ESC_BYTE, 8'h5E, ESC_BYTE, 8'h5D, ESC_BYTE, ESC_BYTE,
    8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h5E, 8'h20, 8'h7C, 8'h0F, 8'hF0
  };

  typedef struct {
    logic [7:0] value;
    bit         hold_for_drain;
  } rx_request_t;

  typedef struct {
    logic [63:0] lo_word;
    logic [63:0] hi_word;
  } packet_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] packet_low_word;
  logic [63:0] packet_high_word;

  rx_request_t rx_requests[$];
  packet_t     expected_packets[$];
  bit          pause_next = 1'b0;

  // Predictor state
  mode_t       frame_mode;
  logic [4:0]  fill_count;
  logic [7:0]  rx_store [STORE_DEPTH];

  logic        byte_taken = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm_send = 1'b0;
  bit          calm_recv = 1'b0;

  int          cycle_count = 0;
  int          bytes_in = 0;
  int          packets_out = 0;
  int          in_stall_cycles = 0;
  int          fail_count = 0;

  escaped_packet_deframer_top DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .packet_low_word  (packet_low_word),
    .packet_high_word (packet_high_word)
  );

  always #2 clk = ~clk;

  function automatic int idle_length(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic store_rx(logic [7:0] v);
    rx_store[fill_count[3:0]] = v;
    fill_count = fill_count + 5'd1;
  endtask

  task automatic deframe_byte(logic [7:0] v);
    packet_t pkt;
    int i;
    if (v == FLAG_BYTE) frame_mode = MODE_WAIT;
    case (frame_mode)
      MODE_NORMAL: begin
        if (v == ESC_BYTE) frame_mode = MODE_ESCAPED;
        else store_rx(v);
      end
      MODE_ESCAPED: begin
        store_rx(v ^ ESC_XOR);
        frame_mode = MODE_NORMAL;
      end
      default: begin
        fill_count = '0;
        frame_mode = (v == FLAG_BYTE) ? MODE_NORMAL : MODE_WAIT;
      end
    endcase
    if (fill_count == 5'(PACKET_BYTES)) begin
      pkt.lo_word = '0;
      pkt.hi_word = '0;
      for (i = 0; i < 8; i++) begin
        if (i < PACKET_BYTES) pkt.lo_word[8*i +: 8] = rx_store[i];
        if (i + 8 < PACKET_BYTES) pkt.hi_word[8*i +: 8] = rx_store[i + 8];
      end
      expected_packets.push_back(pkt);
      frame_mode = MODE_WAIT;
    end
  endtask

  task automatic queue_byte(logic [7:0] v);
    rx_request_t req;
    req.value = v;
    req.hold_for_drain = pause_next;
    pause_next = 1'b0;
    rx_requests.push_back(req);
  endtask

  // Mostly clean frames with random content; some cut short, some pure noise.
  task automatic queue_frame();
    int kind, d, k, n;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      queue_byte(FLAG_BYTE);
      if ($urandom_range(0, 9) == 0) queue_byte(FLAG_BYTE);
      for (k = 0; k < PACKET_BYTES; k++) begin
        d = $urandom_range(0, 255);
        // 0x5E escaped would put a flag on the line
        if (d == FLAG_BYTE || d == ESC_BYTE ||
            (d != (FLAG_BYTE ^ ESC_XOR) && $urandom_range(0, 6) == 0)) begin
          queue_byte(ESC_BYTE);
          queue_byte(8'(d) ^ ESC_XOR);
        end else begin
          queue_byte(8'(d));
        end
      end
    end else if (kind < 92) begin
      queue_byte(FLAG_BYTE);
      n = $urandom_range(0, 15);
      for (k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) queue_byte(ESC_BYTE);
    end else begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Prediction on accepted input requests, checking on accepted results.
  always @(posedge clk) begin : track
    packet_t exp_pkt;
    cycle_count = cycle_count + 1;
    byte_taken <= !rst && in_valid && !in_stall;
    if (rst) begin
      frame_mode = MODE_WAIT;
      fill_count = '0;
    end else begin
      if (in_valid && in_stall) in_stall_cycles = in_stall_cycles + 1;
      if (in_valid && !in_stall) begin
        deframe_byte(rx_byte);
        bytes_in = bytes_in + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_packets.size() == 0) begin
          $error("unexpected packet: low %h high %h", packet_low_word, packet_high_word);
          fail_count = fail_count + 1;
        end else begin
          exp_pkt = expected_packets.pop_front();
          packets_out = packets_out + 1;
          if (packet_low_word !== exp_pkt.lo_word) begin
            $error("packet_low_word mismatch: expected %h, got %h",
                   exp_pkt.lo_word, packet_low_word);
            fail_count = fail_count + 1;
          end
          if (packet_high_word !== exp_pkt.hi_word) begin
            $error("packet_high_word mismatch: expected %h, got %h",
                   exp_pkt.hi_word, packet_high_word);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : drive_in
    rx_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (rx_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (rx_requests[0].hold_for_drain && expected_packets.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        req = rx_requests.pop_front();
        in_valid <= 1'b1;
        rx_byte <= req.value;
        if ($urandom_range(0, 149) == 0) calm_send = !calm_send;
        send_gap <= idle_length(calm_send);
      end
    end
  end

  always @(negedge clk) begin : drive_out
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
      // long hold-off so the output fills and the input backs up
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (recv_gap != 0) begin
      out_stall <= 1'b1;
      recv_gap <= recv_gap - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 299) == 0) calm_recv = !calm_recv;
      recv_gap <= idle_length(calm_recv);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int i;
    bit mid_pause;
    mid_pause = 1'b0;
    for (i = 0; i < N_DIRECTED; i++) queue_byte(DIRECTED[8*(N_DIRECTED-1-i) +: 8]);
    queue_byte(8'h33);
    pause_next = 1'b1;
    while (rx_requests.size() < N_DIRECTED + 1 + RANDOM_BYTES) begin
      if (!mid_pause && rx_requests.size() > 1200) begin
        mid_pause = 1'b1;
        pause_next = 1'b1;
      end
      queue_frame();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (rx_requests.size() != 0 || in_valid || expected_packets.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d line bytes, checked %0d packets; input backed up for %0d cycles",
             bytes_in, packets_out, in_stall_cycles);
    $display("stream mixed clean frames, escapes, cut-short frames and noise");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/epd_pkg.sv
sv/epd_cell.sv
sv/epd_ctrl.sv
sv/escaped_packet_deframer_top.sv
dv/escaped_packet_deframer_top_tb.sv
